>>> hdl/b64c_pkg.sv
// ----------------------------------------------------------------------------
// b64c_pkg: shared types, constants and functions of the base64 codec
// Holds the job descriptor passed from front to back, the direction codes
// and the alphabet mapping in both directions.
// ----------------------------------------------------------------------------
package b64c_pkg;

  // Direction register codes
  typedef enum logic {
    DIR_ENCODE = 1'b0,
    DIR_DECODE = 1'b1
  } b64c_dir_e;

  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  // Job queue depth and pointer width
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // One finished group: up to four result bytes, data[0] goes out first
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;  // index of final byte of the group
    logic            last;      // group closes the stream
    logic            err;       // length error marker
  } b64c_job_t;

  // 6-bit value to alphabet character
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  // Character to 6-bit value; anything outside the alphabet maps to zero
  function automatic logic [5:0] dec_value(input logic [7:0] c);
    logic [7:0] t;
    t = 8'h00;
    if (c >= 8'h41 && c <= 8'h5A) begin
      t = c - 8'h41;
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      t = c - 8'h61 + 8'd26;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd52;
    end else if (c == 8'h2B) begin
      t = 8'd62;
    end else if (c == 8'h2F) begin
      t = 8'd63;
    end
    return t[5:0];
  endfunction

endpackage

>>> hdl/b64c_in_if.sv
// ----------------------------------------------------------------------------
// b64c_in_if: input channel of the base64 codec
// Valid/ready channel carrying one byte or character per transfer.
// ----------------------------------------------------------------------------
interface b64c_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

>>> hdl/b64c_out_if.sv
// ----------------------------------------------------------------------------
// b64c_out_if: output channel of the base64 codec
// Valid/ready channel carrying one result byte per transfer.
// ----------------------------------------------------------------------------
interface b64c_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       length_error;

  modport source (output valid, output out_byte, output out_last,
                  output length_error, input ready);
  modport sink   (input valid, input out_byte, input out_last,
                  input length_error, output ready);
endinterface

>>> hdl/b64c_front.sv
// ----------------------------------------------------------------------------
// b64c_front: input side of the base64 codec
// Holds the direction register, gathers bytes or characters into groups and
// pushes one job per finished group into the queue.
// ----------------------------------------------------------------------------
module b64c_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  b64c_in_if.sink             in_ch,
  input  logic                full_i,
  output logic                push_o,
  output b64c_pkg::b64c_job_t job_o
);
  import b64c_pkg::*;

  b64c_dir_e   dir_q, dir_d;
  logic [23:0] bits_q, bits_d;
  logic [1:0]  fill_q, fill_d;
  logic        pad_q, pad_d;

  logic        accept;
  logic [23:0] enc_bits;
  logic [23:0] dec_bits;
  logic        is_pad;
  logic [1:0]  pad_sub;

  assign in_ch.ready = !full_i;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_pad      = (in_ch.in_byte == PAD_CHAR);

  // Encode: place the byte at its slot in the group
  always_comb begin
    case (fill_q)
      2'd0:    enc_bits = bits_q | {in_ch.in_byte, 16'h0000};
      2'd1:    enc_bits = bits_q | {8'h00, in_ch.in_byte, 8'h00};
      default: enc_bits = bits_q | {16'h0000, in_ch.in_byte};
    endcase
  end

  // Decode: shift in the next sextet
  assign dec_bits = {bits_q[17:0], dec_value(in_ch.in_byte)};
  assign pad_sub  = in_ch.in_last ? ({1'b0, is_pad} + {1'b0, pad_q}) : 2'd0;

  // Group state and job build
  always_comb begin
    dir_d  = dir_q;
    bits_d = bits_q;
    fill_d = fill_q;
    pad_d  = pad_q;
    push_o = 1'b0;
    job_o  = '0;
    if (cfg_we_i) begin
      dir_d  = b64c_dir_e'(cfg_wdata_i);
      bits_d = '0;
      fill_d = '0;
      pad_d  = 1'b0;
    end else if (accept) begin
      case (dir_q)
        DIR_ENCODE: begin
          if (fill_q < 2'd2 && !in_ch.in_last) begin
            bits_d = enc_bits;
            fill_d = fill_q + 2'd1;
          end else begin
            push_o         = 1'b1;
            job_o.data[0]  = enc_char(enc_bits[23:18]);
            job_o.data[1]  = enc_char(enc_bits[17:12]);
            job_o.data[2]  = (fill_q == 2'd0) ? PAD_CHAR : enc_char(enc_bits[11:6]);
            job_o.data[3]  = (fill_q < 2'd2) ? PAD_CHAR : enc_char(enc_bits[5:0]);
            job_o.last_idx = 2'd3;
            job_o.last     = in_ch.in_last;
          end
        end
        DIR_DECODE: begin
          if (fill_q != 2'd3) begin
            if (in_ch.in_last) begin
              // short final group: one error marker
              push_o         = 1'b1;
              job_o.last_idx = 2'd0;
              job_o.last     = 1'b1;
              job_o.err      = 1'b1;
            end else begin
              bits_d = dec_bits;
              fill_d = fill_q + 2'd1;
              pad_d  = is_pad;
            end
          end else begin
            push_o         = 1'b1;
            job_o.data[0]  = dec_bits[23:16];
            job_o.data[1]  = dec_bits[15:8];
            job_o.data[2]  = dec_bits[7:0];
            job_o.last_idx = 2'd2 - pad_sub;
            job_o.last     = in_ch.in_last;
          end
        end
        default: ;
      endcase
      if (push_o) begin
        bits_d = '0;
        fill_d = '0;
        pad_d  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= DIR_ENCODE;
      bits_q <= '0;
      fill_q <= '0;
      pad_q  <= 1'b0;
    end else begin
      dir_q  <= dir_d;
      bits_q <= bits_d;
      fill_q <= fill_d;
      pad_q  <= pad_d;
    end
  end

  // An encode group never holds three bytes between transfers
  a_enc_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_q == DIR_ENCODE |-> fill_q != 2'd3)
    else $error("encode group fill reached three");

endmodule

>>> hdl/b64c_fifo.sv
// ----------------------------------------------------------------------------
// b64c_fifo: job queue between front and back
// Small circular buffer of group jobs, one push and one pop per cycle.
// ----------------------------------------------------------------------------
module b64c_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  b64c_pkg::b64c_job_t job_i,
  input  logic                pop_i,
  output b64c_pkg::b64c_job_t head_o,
  output logic                full_o,
  output logic                empty_o
);
  import b64c_pkg::*;

  b64c_job_t               mem_q [QDEPTH];
  logic [QPTR_W-1:0]       wr_q, wr_d;
  logic [QPTR_W-1:0]       rd_q, rd_d;
  logic [QCNT_W-1:0]       cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];

  // Pointer and occupancy update
  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Job storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("job popped from empty queue");

endmodule

>>> hdl/b64c_back.sv
// ----------------------------------------------------------------------------
// b64c_back: output side of the base64 codec
// Walks the head job one byte per cycle, while the receiver is ready, into
// the output register and releases the job after its final byte.
// ----------------------------------------------------------------------------
module b64c_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  b64c_pkg::b64c_job_t head_i,
  input  logic                empty_i,
  output logic                pop_o,
  b64c_out_if.source          out_ch
);
  import b64c_pkg::*;

  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       err_q;
  logic [1:0] idx_q, idx_d;
  logic       load;
  logic       at_end;

  assign load   = !empty_i && (!valid_q || out_ch.ready);
  assign at_end = (idx_q == head_i.last_idx);
  assign pop_o  = load && at_end;

  // Byte index within the head job and output valid
  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_end ? 2'd0 : idx_q + 2'd1;
    end else if (out_ch.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.data[idx_q];
      last_q <= head_i.last && at_end;
      err_q  <= head_i.err;
    end
  end

  assign out_ch.valid        = valid_q;
  assign out_ch.out_byte     = byte_q;
  assign out_ch.out_last     = last_q;
  assign out_ch.length_error = err_q;

  // A job part-way through stays at the head of the queue
  a_mid_job_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q != 2'd0 |-> !empty_i)
    else $error("job left the queue before its final byte");

  a_err_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && err_q |-> last_q)
    else $error("length error marker without end of stream");

endmodule

>>> hdl/base64_stream_codec.sv
// ----------------------------------------------------------------------------
// base64_stream_codec: streaming base64 encoder and decoder
// Direction set by a one-bit register; front gathers groups, a four-job
// queue decouples it from the back, which emits one result per ready cycle.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_we_i/cfg_wdata_i write the direction (0 encode, 1 decode) while
//   the codec is idle; a write also drops any partial group.
//   in_ch takes one byte (encode) or character (decode) per transfer,
//   in_last marking the end of a stream. out_ch gives one result per
//   transfer; length_error comes with out_last on a short decode stream.
// Timing:
//   The first result of a group is loaded into the output register after
//   the job of that group has been written into the queue. While the
//   receiver is ready the back emits one result per cycle; encoding is
//   bound by the single output port, as three input bytes give four
//   results, and decoding sustains one character per cycle.
// Reset and stall:
//   Reset selects encode and empties the group and the queue. When the
//   receiver stalls, the output register holds and the queue absorbs up to
//   four groups before in_ch.ready drops.
// ----------------------------------------------------------------------------
module base64_stream_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  b64c_in_if.sink    in_ch,
  b64c_out_if.source out_ch
);
  import b64c_pkg::*;

  logic      push;
  logic      pop;
  logic      full;
  logic      empty;
  b64c_job_t job;
  b64c_job_t head;

  b64c_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_ch       (in_ch),
    .full_i      (full),
    .push_o      (push),
    .job_o       (job)
  );

  b64c_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  b64c_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule
